>>> rtl/macd_pkg.sv
// Shared types, constants and the datapath command/status structs for the MACD histogram block.
package macd_pkg;

   localparam int MaxPeriod    = 256;
   localparam int PriceBits    = 32;
   localparam int FracBits     = 16;
   localparam int AlphaBits    = 24;
   localparam int PeriodBits   = 9;
   localparam int IndexBits    = 10;
   localparam int AvgBits      = 48;
   localparam int HistBits     = 50;
   localparam int AlphaW       = 25;
   localparam int AccBits      = 72;
   localparam int QuotBits     = 50;

   localparam logic [1:0] CSR_FAST   = 2'd0;
   localparam logic [1:0] CSR_SLOW   = 2'd1;
   localparam logic [1:0] CSR_SIGNAL = 2'd2;

   // unit select for the shared update stage
   localparam logic [1:0] UNIT_FAST   = 2'd0;
   localparam logic [1:0] UNIT_SLOW   = 2'd1;
   localparam logic [1:0] UNIT_SIGNAL = 2'd2;

   typedef struct packed {
      logic [PriceBits-1:0] close_price;
      logic                 new_series;
   } req_type;

   typedef struct packed {
      logic signed [HistBits-1:0] histogram;
      logic                       valid_res;
   } rsp_type;

   typedef struct packed {
      logic       clear;       // restart series
      logic       load_x;      // capture price
      logic       start_unit;  // begin one average update
      logic [1:0] unit;        // which average
      logic       div_step;    // one divider/multiplier step
      logic       finish_unit; // write back the average
      logic       make_hist;   // form the result word
      logic       bump_index;  // advance sample index
   } dp_cmd_type;

   typedef struct packed {
      logic seed_phase;  // unit is still summing its seed
      logic seed_last;   // this sample completes the seed
      logic in_signal;   // MACD line is defined
      logic hist_valid;  // histogram is valid
      logic step_done;   // multi-cycle op finished
   } dp_sts_type;

   function automatic logic [PeriodBits-1:0] clamp_period(input logic [PeriodBits-1:0] p);
      logic [PeriodBits-1:0] r;
      r = p;
      if (p == '0) r = PeriodBits'(1);
      else if (p > PeriodBits'(MaxPeriod)) r = PeriodBits'(MaxPeriod);
      return r;
   endfunction

endpackage

>>> rtl/macd_histogram_stream.sv
// Top level of the streaming MACD histogram block.
// Usage:
//  - req channel: one word per closing price (Q.8) plus new_series, which
//    restarts all averages so that price becomes sample zero.
//  - rsp channel: one word per price, histogram (signed Q.16) and valid_res,
//    which rises once slow+signal-1 samples have been seen.
//  - csr port: write fast/slow/signal periods at index 0/1/2. Each write
//    recomputes the effective periods and restarts the series. Write only
//    while no word is in flight.
// Operation: each price runs the fast, slow and (once the MACD line exists) the
//    signal average through one shared divide/multiply unit. An average only
//    adds to its seed sum while it seeds, runs a 26-step alpha division plus 13
//    4-bit multiply steps for an alpha update, and finishes its seed with the
//    50-step divide. A last step then forms the result word; one price is
//    handled at a time.
// Reset: periods return to 12/26/9, averages and sample count clear.
// Stall: a finished result is held in the output register until taken;
//    the next price is accepted only after it leaves.
module macd_histogram_stream (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  macd_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output macd_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [8:0]         csr_wdata
);
   import macd_pkg::*;

   logic [8:0] fast_ff, fast_in, slow_ff, slow_in, sig_ff, sig_in;
   logic [8:0] eff_fast, eff_slow, eff_signal;
   logic       cfg_hit;
   dp_cmd_type cmd;
   dp_sts_type sts;

   // hold the raw periods; a write to a listed register restarts the series
   always_comb begin
      fast_in = fast_ff; slow_in = slow_ff; sig_in = sig_ff; cfg_hit = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_FAST:   begin fast_in = csr_wdata; cfg_hit = 1'b1; end
            CSR_SLOW:   begin slow_in = csr_wdata; cfg_hit = 1'b1; end
            CSR_SIGNAL: begin sig_in  = csr_wdata; cfg_hit = 1'b1; end
            default:    cfg_hit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff <= 9'd12; slow_ff <= 9'd26; sig_ff <= 9'd9;
      end else begin
         fast_ff <= fast_in; slow_ff <= slow_in; sig_ff <= sig_in;
      end
   end

   // clamp periods; fast may not exceed slow
   assign eff_slow   = clamp_period(slow_ff);
   assign eff_fast   = (clamp_period(fast_ff) > eff_slow) ? eff_slow : clamp_period(fast_ff);
   assign eff_signal = clamp_period(sig_ff);

   macd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .req_new_series(req_data.new_series),
      .rsp_valid, .rsp_ready, .cfg_clear(cfg_hit), .sts, .cmd
   );

   macd_datapath u_dp (
      .clock, .reset, .req_word(req_data), .eff_fast, .eff_slow, .eff_signal,
      .cmd, .sts, .rsp_word(rsp_data)
   );
endmodule

>>> rtl/macd_datapath.sv
// Datapath: averages, shared seed divider and alpha multiplier, result register.
module macd_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  macd_pkg::req_type        req_word,
   input  logic [8:0]               eff_fast,
   input  logic [8:0]               eff_slow,
   input  logic [8:0]               eff_signal,
   input  macd_pkg::dp_cmd_type     cmd,
   output macd_pkg::dp_sts_type     sts,
   output macd_pkg::rsp_type        rsp_word
);
   import macd_pkg::*;

   // fast and slow hold nonnegative values only; a full seed sum needs all 48 bits
   logic [AvgBits-1:0]         fast_ff, fast_in, slow_ff, slow_in;
   logic signed [HistBits-1:0] sig_ff, sig_in;
   logic signed [AvgBits-1:0]  x_ff, x_in;
   logic [IndexBits-1:0]       idx_ff, idx_in;
   logic [5:0]                 cnt_ff, cnt_in;
   logic                       seeding_ff, seeding_in;
   logic                       divide_ff, divide_in;
   logic                       neg_ff, neg_in;
   logic [QuotBits-1:0]        rem_ff, rem_in, quo_ff, quo_in;
   logic signed [AccBits-1:0]  acc_ff, acc_in;
   logic signed [HistBits+1:0] d_ff, d_in;
   logic [AlphaW-1:0]          a_ff, a_in;
   rsp_type                    rsp_ff, rsp_in;

   logic [IndexBits-1:0] k_unit, n_unit, lim;
   logic [8:0]           n_sel;
   logic signed [HistBits-1:0] avg_sel, xin_sel, macd;
   logic signed [HistBits+1:0] sum;
   logic [QuotBits:0]    trial;

   assign macd = HistBits'(fast_ff) - HistBits'(slow_ff);

   always_comb begin
      case (cmd.unit)
         UNIT_FAST:   begin n_sel = eff_fast;   avg_sel = HistBits'(fast_ff); end
         UNIT_SLOW:   begin n_sel = eff_slow;   avg_sel = HistBits'(slow_ff); end
         default:     begin n_sel = eff_signal; avg_sel = sig_ff; end
      endcase
      xin_sel = (cmd.unit == UNIT_SIGNAL) ? macd : HistBits'(x_ff);
      k_unit  = (cmd.unit == UNIT_SIGNAL) ? idx_ff - IndexBits'(eff_slow - 9'd1) : idx_ff;
      n_unit  = IndexBits'(n_sel);
      lim     = IndexBits'(eff_slow) + IndexBits'(eff_signal) - IndexBits'(1);
      sum     = (HistBits+2)'(avg_sel) + (HistBits+2)'(xin_sel);
   end

   // alpha = floor(2^25/(n+1)) computed by restoring division on the same divider
   logic [QuotBits-1:0] div_num;
   logic [QuotBits-1:0] div_den;
   assign div_den = divide_ff ? QuotBits'(n_sel) : QuotBits'(n_sel) + QuotBits'(1);
   assign trial   = {rem_ff, quo_ff[QuotBits-1]} - {1'b0, div_den};

   always_comb begin
      fast_in = fast_ff; slow_in = slow_ff; sig_in = sig_ff; x_in = x_ff;
      idx_in = idx_ff; cnt_in = cnt_ff; seeding_in = seeding_ff;
      divide_in = divide_ff; neg_in = neg_ff; rem_in = rem_ff; quo_in = quo_ff;
      acc_in = acc_ff; d_in = d_ff; a_in = a_ff; rsp_in = rsp_ff;
      div_num = '0;
      sts.seed_phase = (k_unit < n_unit);
      sts.seed_last  = (k_unit == n_unit - IndexBits'(1));
      sts.in_signal  = (idx_ff >= IndexBits'(eff_slow) - IndexBits'(1));
      sts.hist_valid = (idx_ff >= lim - IndexBits'(1)) && sts.in_signal;
      sts.step_done  = (cnt_ff == '0);

      if (cmd.load_x) x_in = AvgBits'(req_word.close_price) <<< (FracBits - 8);
      if (cmd.clear) begin
         idx_in = '0; fast_in = '0; slow_in = '0; sig_in = '0;
      end
      if (cmd.start_unit) begin
         rem_in  = '0;
         acc_in  = '0;
         if (sts.seed_phase) begin
            seeding_in = 1'b1;
            d_in       = sum;
            if (sts.seed_last) begin
               // divide |sum| by n: 50 steps
               divide_in = 1'b1;
               neg_in    = sum[HistBits+1];
               div_num   = QuotBits'(sum[HistBits+1] ? -sum : sum);
               quo_in    = div_num;
               cnt_in    = 6'(QuotBits);
            end else begin
               divide_in = 1'b0;
               cnt_in    = '0;
            end
         end else begin
            // compute alpha by division of 2^25 by n+1 (26 steps), then multiply
            seeding_in = 1'b0;
            divide_in  = 1'b0;
            d_in       = (HistBits+2)'(xin_sel) - (HistBits+2)'(avg_sel);
            quo_in     = QuotBits'(1) << (QuotBits - 1);
            cnt_in     = 6'd26 + 6'd13;
         end
      end else if (cmd.div_step && cnt_ff != '0) begin
         cnt_in = cnt_ff - 6'd1;
         if (seeding_ff || cnt_ff > 6'd13) begin
            if (!trial[QuotBits]) begin
               rem_in = trial[QuotBits-1:0];
               quo_in = {quo_ff[QuotBits-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[QuotBits-2:0], quo_ff[QuotBits-1]};
               quo_in = {quo_ff[QuotBits-2:0], 1'b0};
            end
            if (!seeding_ff && cnt_ff == 6'd14)
               a_in = trial[QuotBits] ? AlphaW'({quo_ff[23:0], 1'b0})
                                      : AlphaW'({quo_ff[23:0], 1'b1});
         end else begin
            // 13 shift-add steps of 4 alpha bits each: (d * alpha) >> 24, floor
            acc_in = acc_ff + AccBits'((d_ff * $signed({1'b0, a_ff[3:0]})) <<< (4*(13 - int'(cnt_ff))));
            a_in   = a_ff >> 4;
         end
      end
      if (cmd.finish_unit) begin
         logic signed [HistBits+1:0] nv;
         nv = '0;
         if (seeding_ff)
            nv = divide_ff ? (neg_ff ? -(HistBits+2)'(quo_ff) : (HistBits+2)'(quo_ff)) : d_ff;
         else
            nv = (HistBits+2)'(avg_sel) + (HistBits+2)'(acc_ff >>> AlphaBits);
         case (cmd.unit)
            UNIT_FAST: fast_in = AvgBits'(nv);
            UNIT_SLOW: slow_in = AvgBits'(nv);
            default:   sig_in  = HistBits'(nv);
         endcase
      end
      if (cmd.make_hist) begin
         rsp_in.valid_res = sts.hist_valid;
         rsp_in.histogram = sts.hist_valid ? macd - sig_ff : '0;
      end
      if (cmd.bump_index && idx_ff < lim) idx_in = idx_ff + IndexBits'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0; fast_ff <= '0; slow_ff <= '0; sig_ff <= '0;
         cnt_ff <= '0; seeding_ff <= 1'b0; divide_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in; fast_ff <= fast_in; slow_ff <= slow_in; sig_ff <= sig_in;
         cnt_ff <= cnt_in; seeding_ff <= seeding_in;
         divide_ff <= divide_in;
      end
      x_ff <= x_in; neg_ff <= neg_in; rem_ff <= rem_in; quo_ff <= quo_in;
      acc_ff <= acc_in; d_ff <= d_in; a_ff <= a_in; rsp_ff <= rsp_in;
   end

   assign rsp_word = rsp_ff;
endmodule

>>> rtl/macd_ctrl.sv
// Sequencer for the MACD datapath and the request/response handshake.
module macd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_new_series,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 cfg_clear,
   input  macd_pkg::dp_sts_type sts,
   output macd_pkg::dp_cmd_type cmd
);
   import macd_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_DONE  = 3'd3;
   localparam logic [2:0] ST_HIST  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] unit_ff, unit_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      unit_in  = unit_ff;
      cmd      = '0;
      cmd.unit = unit_ff;
      cmd.clear = cfg_clear;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_x = 1'b1;
               cmd.clear  = cfg_clear | req_new_series;
               unit_in    = UNIT_FAST;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            cmd.start_unit = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.div_step = 1'b1;
            if (sts.step_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.finish_unit = 1'b1;
            if (unit_ff == UNIT_FAST) begin
               unit_in = UNIT_SLOW; state_in = ST_START;
            end else if (unit_ff == UNIT_SLOW && sts.in_signal) begin
               unit_in = UNIT_SIGNAL; state_in = ST_START;
            end else begin
               state_in = ST_HIST;
            end
         end
         ST_HIST: begin
            cmd.make_hist  = 1'b1;
            cmd.bump_index = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         unit_ff  <= UNIT_FAST;
      end else begin
         state_ff <= state_in;
         unit_ff  <= unit_in;
      end
   end
endmodule

>>> rtl/macd_checker.sv
// Port-level checker for the MACD histogram block, bound to the top level.
module macd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input macd_pkg::rsp_type rsp_data
);
   import macd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped under stall");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result pending");

   a_warmup_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |-> rsp_data.histogram == '0)
      else $error("nonzero histogram in warm-up");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted back to back");
endmodule

bind macd_histogram_stream macd_checker u_macd_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
